// ===== rtl/cqfg_pkg.sv =====
// shared constants and helpers for the cropped quad fill geometry block
`default_nettype none

package cqfg_pkg;

   typedef logic [2:0] mode_type;
   typedef logic [1:0] corner_type;

   localparam mode_type MODE_FULL   = 3'd0;
   localparam mode_type MODE_BOTTOM = 3'd1;
   localparam mode_type MODE_TOP    = 3'd2;
   localparam mode_type MODE_RIGHT  = 3'd3;
   localparam mode_type MODE_LEFT   = 3'd4;

   localparam corner_type CORNER_TL = 2'd0;
   localparam corner_type CORNER_BR = 2'd3;

   localparam logic [14:0] ONE_Q14     = 15'd16384;
   localparam logic [15:0] VSCALE_INIT = 16'd4096;

   // clamp a widened texture coordinate to the signed 20-bit output range
   function automatic logic [19:0] sat20(input logic signed [23:0] val);
      logic [19:0] res;
      if (val > 24'sd524287) begin
         res = 20'h7FFFF;
      end else if (val < -24'sd524288) begin
         res = 20'h80000;
      end else begin
         res = val[19:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cropped_quad_fill_geometry.sv =====
// cropped quad fill geometry: crop, fill and corner vertex generation
//
// A quad word is taken on a rising edge with start high and busy low. The
// word carries the source texture edges, the crop fractions, the fill ratio
// and mode and the quad size. The block answers with four vertex words in
// corner order 0 to 3, one per cycle, each marked by rsp_strobe for exactly
// one cycle; corner 3 carries rsp_last_of_quad. A fill mode above 4 gives a
// single word with rsp_mode_ok low, all fields zero and the last flag set.
// The height scale register is written through csr_write_en/csr_write_data.
// The pipeline has six register stages (a to f) plus an output stage (s),
// so several quads can be in flight at once. The output stage sends one
// vertex per cycle and so sets the quad rate; an invalid mode gives one word
// only. Busy rises when the stages behind the output stage are full. The
// receiver cannot stall. A synchronous reset empties the pipeline and sets
// the scale to 1.0 (4096).
`default_nettype none

module cropped_quad_fill_geometry
   import cqfg_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire signed [15:0]  req_src_u_left,
   input  wire signed [15:0]  req_src_u_right,
   input  wire signed [15:0]  req_src_v_top,
   input  wire signed [15:0]  req_src_v_bottom,
   input  wire signed [15:0]  req_crop_left,
   input  wire signed [15:0]  req_crop_right,
   input  wire signed [15:0]  req_crop_top,
   input  wire signed [15:0]  req_crop_bottom,
   input  wire signed [15:0]  req_fill_ratio,
   input  wire        [2:0]   req_fill_mode,
   input  wire        [15:0]  req_quad_width,
   input  wire        [15:0]  req_quad_height,
   input  wire                csr_write_en,
   input  wire        [15:0]  csr_write_data,
   output logic               rsp_strobe,
   output logic               rsp_mode_ok,
   output logic       [1:0]   rsp_corner,
   output logic       [15:0]  rsp_x_pos,
   output logic       [19:0]  rsp_y_pos,
   output logic signed [19:0] rsp_tex_u,
   output logic signed [19:0] rsp_tex_v,
   output logic               rsp_last_of_quad
);

   logic [15:0] vscale_ff;

   logic en_a, en_b, en_c, en_d, en_e, en_f, en_s;
   logic accept;

   // stage a
   logic               a_v_ff;
   logic signed [15:0] a_ul_ff, a_vt_ff, a_cl_ff, a_cr_ff, a_ct_ff, a_cb_ff;
   logic signed [16:0] a_su_ff, a_sv_ff, a_su_in, a_sv_in;
   logic [14:0]        a_ratio_ff, a_ratio_in;
   mode_type           a_mode_ff;
   logic [15:0]        a_width_ff;
   logic [31:0]        a_hp_ff, a_hp_in;

   // stage b
   logic               b_v_ff;
   logic signed [15:0] b_ul_ff, b_vt_ff;
   logic signed [33:0] b_pcl_ff, b_pcr_ff, b_pct_ff, b_pcb_ff;
   logic signed [33:0] b_pcl_in, b_pcr_in, b_pct_in, b_pcb_in;
   logic [32:0]        b_hsum;
   logic [20:0]        b_yb_ff, b_yb_in;
   logic [14:0]        b_ratio_ff;
   mode_type           b_mode_ff;
   logic [15:0]        b_width_ff;

   // stage c
   logic               c_v_ff;
   logic signed [33:0] c_rcl, c_rcr, c_rct, c_rcb;
   logic signed [20:0] c_ul_ff, c_ur_ff, c_vt_ff, c_vb_ff;
   logic signed [20:0] c_ul_in, c_ur_in, c_vt_in, c_vb_in;
   logic [20:0]        c_yb_ff;
   logic [14:0]        c_ratio_ff;
   mode_type           c_mode_ff;
   logic [15:0]        c_width_ff;

   // stage d
   logic               d_v_ff;
   logic               c_vert;
   logic signed [20:0] d_ul_ff, d_ur_ff, d_vt_ff, d_vb_ff;
   logic signed [21:0] d_span_ff, d_span_in;
   logic [20:0]        d_pos_ff, d_pos_in;
   logic [14:0]        d_f_ff, d_f_in;
   logic [20:0]        d_yb_ff;
   mode_type           d_mode_ff;
   logic [15:0]        d_width_ff;

   // stage e
   logic               e_v_ff;
   logic signed [36:0] e_tp_ff, e_tp_in;
   logic [35:0]        e_pp_ff, e_pp_in;
   logic signed [20:0] e_ul_ff, e_ur_ff, e_vt_ff, e_vb_ff;
   logic [20:0]        e_yb_ff;
   mode_type           e_mode_ff;
   logic [15:0]        e_width_ff;

   // stage f
   logic               f_v_ff;
   logic               e_vert;
   logic signed [36:0] f_tsum;
   logic signed [22:0] f_rt;
   logic [35:0]        f_psum;
   logic [21:0]        f_rp;
   logic signed [20:0] f_base;
   logic signed [23:0] f_nt;
   logic               f_ok_ff, f_ok_in;
   logic [15:0]        f_xl_ff, f_xr_ff, f_xl_in, f_xr_in;
   logic [19:0]        f_yt_ff, f_yb_ff, f_yt_in, f_yb_in;
   logic signed [23:0] f_ul_ff, f_ur_ff, f_vt_ff, f_vb_ff;
   logic signed [23:0] f_ul_in, f_ur_in, f_vt_in, f_vb_in;

   // output stage
   logic               s_v_ff;
   corner_type         s_corner_ff;
   logic               s_ok_ff;
   logic               s_last;
   logic [15:0]        s_xl_ff, s_xr_ff, s_xl_in, s_xr_in;
   logic [19:0]        s_yt_ff, s_yb_ff, s_yt_in, s_yb_in;
   logic [19:0]        s_ul_ff, s_ur_ff, s_vt_ff, s_vb_ff;
   logic [19:0]        s_ul_in, s_ur_in, s_vt_in, s_vb_in;

   // stall chain
   assign s_last = !s_ok_ff || (s_corner_ff == CORNER_BR);
   assign en_s   = !s_v_ff || s_last;
   assign en_f   = !f_v_ff || en_s;
   assign en_e   = !e_v_ff || en_f;
   assign en_d   = !d_v_ff || en_e;
   assign en_c   = !c_v_ff || en_d;
   assign en_b   = !b_v_ff || en_c;
   assign en_a   = !a_v_ff || en_b;
   assign busy   = !en_a;
   assign accept = start && en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         vscale_ff   <= VSCALE_INIT;
         a_v_ff      <= 1'b0;
         b_v_ff      <= 1'b0;
         c_v_ff      <= 1'b0;
         d_v_ff      <= 1'b0;
         e_v_ff      <= 1'b0;
         f_v_ff      <= 1'b0;
         s_v_ff      <= 1'b0;
         s_corner_ff <= CORNER_TL;
      end else begin
         if (csr_write_en) begin
            vscale_ff <= csr_write_data;
         end
         if (en_a) a_v_ff <= accept;
         if (en_b) b_v_ff <= a_v_ff;
         if (en_c) c_v_ff <= b_v_ff;
         if (en_d) d_v_ff <= c_v_ff;
         if (en_e) e_v_ff <= d_v_ff;
         if (en_f) f_v_ff <= e_v_ff;
         if (en_s) begin
            s_v_ff      <= f_v_ff;
            s_corner_ff <= CORNER_TL;
         end else begin
            s_corner_ff <= s_corner_ff + 2'd1;
         end
      end
   end

   // stage a: spans, ratio clamp, height product
   always_comb begin
      a_su_in = 17'(req_src_u_right) - 17'(req_src_u_left);
      a_sv_in = 17'(req_src_v_bottom) - 17'(req_src_v_top);
      a_hp_in = 32'(vscale_ff) * 32'(req_quad_height);
      if (req_fill_ratio[15]) begin
         a_ratio_in = 15'd0;
      end else if (req_fill_ratio > 16'sd16384) begin
         a_ratio_in = ONE_Q14;
      end else begin
         a_ratio_in = req_fill_ratio[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_ul_ff    <= req_src_u_left;
         a_vt_ff    <= req_src_v_top;
         a_cl_ff    <= req_crop_left;
         a_cr_ff    <= req_crop_right;
         a_ct_ff    <= req_crop_top;
         a_cb_ff    <= req_crop_bottom;
         a_su_ff    <= a_su_in;
         a_sv_ff    <= a_sv_in;
         a_ratio_ff <= a_ratio_in;
         a_mode_ff  <= req_fill_mode;
         a_width_ff <= req_quad_width;
         a_hp_ff    <= a_hp_in;
      end
   end

   // stage b: crop products, full height
   always_comb begin
      b_pcl_in = 34'(a_cl_ff) * 34'(a_su_ff);
      b_pcr_in = 34'(a_cr_ff) * 34'(a_su_ff);
      b_pct_in = 34'(a_ct_ff) * 34'(a_sv_ff);
      b_pcb_in = 34'(a_cb_ff) * 34'(a_sv_ff);
      b_hsum   = 33'(a_hp_ff) + 33'd2048;
      b_yb_in  = b_hsum[32:12];
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_ul_ff    <= a_ul_ff;
         b_vt_ff    <= a_vt_ff;
         b_pcl_ff   <= b_pcl_in;
         b_pcr_ff   <= b_pcr_in;
         b_pct_ff   <= b_pct_in;
         b_pcb_ff   <= b_pcb_in;
         b_yb_ff    <= b_yb_in;
         b_ratio_ff <= a_ratio_ff;
         b_mode_ff  <= a_mode_ff;
         b_width_ff <= a_width_ff;
      end
   end

   // stage c: cropped texture edges
   always_comb begin
      c_rcl   = b_pcl_ff + 34'sd8192;
      c_rcr   = b_pcr_ff + 34'sd8192;
      c_rct   = b_pct_ff + 34'sd8192;
      c_rcb   = b_pcb_ff + 34'sd8192;
      c_ul_in = 21'(b_ul_ff) + 21'($signed(c_rcl[33:14]));
      c_ur_in = 21'(b_ul_ff) + 21'($signed(c_rcr[33:14]));
      c_vt_in = 21'(b_vt_ff) + 21'($signed(c_rct[33:14]));
      c_vb_in = 21'(b_vt_ff) + 21'($signed(c_rcb[33:14]));
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_ul_ff    <= c_ul_in;
         c_ur_ff    <= c_ur_in;
         c_vt_ff    <= c_vt_in;
         c_vb_ff    <= c_vb_in;
         c_yb_ff    <= b_yb_ff;
         c_ratio_ff <= b_ratio_ff;
         c_mode_ff  <= b_mode_ff;
         c_width_ff <= b_width_ff;
      end
   end

   // stage d: pick the shrinking edge's span, extent and factor
   always_comb begin
      c_vert = (c_mode_ff == MODE_BOTTOM) || (c_mode_ff == MODE_TOP);
      if (c_vert) begin
         d_span_in = 22'(c_vb_ff) - 22'(c_vt_ff);
         d_pos_in  = c_yb_ff;
      end else begin
         d_span_in = 22'(c_ur_ff) - 22'(c_ul_ff);
         d_pos_in  = 21'(c_width_ff);
      end
      if ((c_mode_ff == MODE_BOTTOM) || (c_mode_ff == MODE_RIGHT)) begin
         d_f_in = c_ratio_ff;
      end else begin
         d_f_in = ONE_Q14 - c_ratio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_ul_ff    <= c_ul_ff;
         d_ur_ff    <= c_ur_ff;
         d_vt_ff    <= c_vt_ff;
         d_vb_ff    <= c_vb_ff;
         d_span_ff  <= d_span_in;
         d_pos_ff   <= d_pos_in;
         d_f_ff     <= d_f_in;
         d_yb_ff    <= c_yb_ff;
         d_mode_ff  <= c_mode_ff;
         d_width_ff <= c_width_ff;
      end
   end

   // stage e: fill products
   always_comb begin
      e_tp_in = 37'(d_span_ff) * 37'($signed({1'b0, d_f_ff}));
      e_pp_in = 36'(d_pos_ff) * 36'(d_f_ff);
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_tp_ff    <= e_tp_in;
         e_pp_ff    <= e_pp_in;
         e_ul_ff    <= d_ul_ff;
         e_ur_ff    <= d_ur_ff;
         e_vt_ff    <= d_vt_ff;
         e_vb_ff    <= d_vb_ff;
         e_yb_ff    <= d_yb_ff;
         e_mode_ff  <= d_mode_ff;
         e_width_ff <= d_width_ff;
      end
   end

   // stage f: round and place the moved edge
   always_comb begin
      e_vert  = (e_mode_ff == MODE_BOTTOM) || (e_mode_ff == MODE_TOP);
      f_tsum  = e_tp_ff + 37'sd8192;
      f_rt    = $signed(f_tsum[36:14]);
      f_psum  = e_pp_ff + 36'd8192;
      f_rp    = f_psum[35:14];
      f_base  = e_vert ? e_vt_ff : e_ul_ff;
      f_nt    = 24'(f_base) + 24'(f_rt);
      f_ok_in = (e_mode_ff <= MODE_LEFT);
      f_xl_in = 16'd0;
      f_xr_in = e_width_ff;
      f_yt_in = 20'd0;
      f_yb_in = e_yb_ff[19:0];
      f_ul_in = 24'(e_ul_ff);
      f_ur_in = 24'(e_ur_ff);
      f_vt_in = 24'(e_vt_ff);
      f_vb_in = 24'(e_vb_ff);
      case (e_mode_ff)
         MODE_BOTTOM: begin
            f_yb_in = f_rp[19:0];
            f_vb_in = f_nt;
         end
         MODE_TOP: begin
            f_yt_in = f_rp[19:0];
            f_vt_in = f_nt;
         end
         MODE_RIGHT: begin
            f_xr_in = f_rp[15:0];
            f_ur_in = f_nt;
         end
         MODE_LEFT: begin
            f_xl_in = f_rp[15:0];
            f_ul_in = f_nt;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         f_ok_ff <= f_ok_in;
         f_xl_ff <= f_xl_in;
         f_xr_ff <= f_xr_in;
         f_yt_ff <= f_yt_in;
         f_yb_ff <= f_yb_in;
         f_ul_ff <= f_ul_in;
         f_ur_ff <= f_ur_in;
         f_vt_ff <= f_vt_in;
         f_vb_ff <= f_vb_in;
      end
   end

   // output stage: saturate, zero an invalid word, send one corner a cycle
   always_comb begin
      if (f_ok_ff) begin
         s_xl_in = f_xl_ff;
         s_xr_in = f_xr_ff;
         s_yt_in = f_yt_ff;
         s_yb_in = f_yb_ff;
         s_ul_in = sat20(f_ul_ff);
         s_ur_in = sat20(f_ur_ff);
         s_vt_in = sat20(f_vt_ff);
         s_vb_in = sat20(f_vb_ff);
      end else begin
         s_xl_in = 16'd0;
         s_xr_in = 16'd0;
         s_yt_in = 20'd0;
         s_yb_in = 20'd0;
         s_ul_in = 20'd0;
         s_ur_in = 20'd0;
         s_vt_in = 20'd0;
         s_vb_in = 20'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s) begin
         s_ok_ff <= f_ok_ff;
         s_xl_ff <= s_xl_in;
         s_xr_ff <= s_xr_in;
         s_yt_ff <= s_yt_in;
         s_yb_ff <= s_yb_in;
         s_ul_ff <= s_ul_in;
         s_ur_ff <= s_ur_in;
         s_vt_ff <= s_vt_in;
         s_vb_ff <= s_vb_in;
      end
   end

   always_comb begin
      rsp_strobe       = s_v_ff;
      rsp_mode_ok      = s_ok_ff;
      rsp_corner       = s_corner_ff;
      rsp_x_pos        = s_corner_ff[0] ? s_xr_ff : s_xl_ff;
      rsp_y_pos        = s_corner_ff[1] ? s_yb_ff : s_yt_ff;
      rsp_tex_u        = $signed(s_corner_ff[0] ? s_ur_ff : s_ul_ff);
      rsp_tex_v        = $signed(s_corner_ff[1] ? s_vb_ff : s_vt_ff);
      rsp_last_of_quad = s_last;
   end

endmodule

`default_nettype wire

// ===== rtl/cqfg_checker.sv =====
// port-level checks for the cropped quad fill geometry block, with bind
`default_nettype none

module cqfg_checker
   import cqfg_pkg::*;
(
   input wire                clock,
   input wire                reset,
   input wire                busy,
   input wire                rsp_strobe,
   input wire                rsp_mode_ok,
   input wire        [1:0]   rsp_corner,
   input wire        [15:0]  rsp_x_pos,
   input wire        [19:0]  rsp_y_pos,
   input wire signed [19:0]  rsp_tex_u,
   input wire signed [19:0]  rsp_tex_v,
   input wire                rsp_last_of_quad
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("word or busy right after reset");

   // corners of a valid quad come on consecutive cycles
   a_corner_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_mode_ok && !rsp_last_of_quad
      |=> rsp_strobe && (rsp_corner == 2'($past(rsp_corner) + 2'd1)))
      else $error("corner sequence broken");

   // a word after a last word starts a new quad
   a_new_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_quad |=> !rsp_strobe || (rsp_corner == CORNER_TL))
      else $error("quad does not start at corner 0");

   // invalid mode word is a lone zero word
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_mode_ok
      |-> rsp_last_of_quad && (rsp_corner == CORNER_TL) && (rsp_x_pos == 16'd0)
          && (rsp_y_pos == 20'd0) && (rsp_tex_u == 20'sd0) && (rsp_tex_v == 20'sd0))
      else $error("bad error word");

endmodule

bind cropped_quad_fill_geometry cqfg_checker u_cqfg_checker (.*);

`default_nettype wire
